### hdl/sqmm_pkg.sv
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared types and constants of the square matrix multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqmm_pkg;

  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int IDX_W  = 3;   // row / column index
  localparam int DIM_W  = 4;   // size register, wide enough for a count of eight
  localparam int PROD_W = 32;  // Q16.16 single product
  localparam int ACC_W  = 35;  // Q19.16 sum of up to eight products
  localparam int CMD_W  = 2;

  localparam logic [DIM_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_COMPUTE     = 2'd2,
    CMD_UNUSED      = 2'd3
  } sqmm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } sqmm_state_t;

  // One multiply-accumulate step as it travels down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;      // first term of a product element
    logic             last_term;  // last term of a product element
    logic             last_elem;  // final product element of the run
  } sqmm_step_t;

endpackage

`default_nettype wire

### hdl/sqmm_mem.sv
// ----------------------------------------------------------------------------
// sqmm_mem
// Element stores for both matrices, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqmm_mem
  import sqmm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                     clk,
  input  wire                     we_first,
  input  wire                     we_second,
  input  wire        [AW-1:0]     wr_addr,
  input  wire signed [ELEM_W-1:0] wr_data,
  input  wire                     rd_en,
  input  wire        [AW-1:0]     rd_addr_first,
  input  wire        [AW-1:0]     rd_addr_second,
  output logic signed [ELEM_W-1:0] rd_first_r,
  output logic signed [ELEM_W-1:0] rd_second_r
);

  logic signed [ELEM_W-1:0] first_mem [DEPTH];
  logic signed [ELEM_W-1:0] second_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_first) begin
      first_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_first_r <= first_mem[rd_addr_first];
    end
  end

  always_ff @(posedge clk) begin
    if (we_second) begin
      second_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_second_r <= second_mem[rd_addr_second];
    end
  end

endmodule

`default_nettype wire

### hdl/sqmm_ctrl.sv
// ----------------------------------------------------------------------------
// sqmm_ctrl
// Sequencer: walks i, j, k over the active size and issues element reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqmm_ctrl
  import sqmm_pkg::*;
#(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               go,
  input  wire [DIM_W-1:0]   size,
  input  wire               done,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr_first,
  output logic [AW-1:0]     rd_addr_second,
  output sqmm_step_t        step
);

  sqmm_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] dim;
  logic [IDX_W-1:0] last_idx;
  logic             k_end, j_end, i_end;

  // Clamp size into 1..MAX_DIM.
  always_comb begin
    if (size == '0) begin
      dim = DIM_W'(1);
    end else if (size > DIM_W'(MAX_DIM)) begin
      dim = DIM_W'(MAX_DIM);
    end else begin
      dim = size;
    end
  end

  assign last_idx = IDX_W'(dim - DIM_W'(1));
  assign k_end    = (k_r == last_idx);
  assign j_end    = (j_r == last_idx);
  assign i_end    = (i_r == last_idx);

  assign busy  = (state_r != ST_IDLE);
  assign rd_en = (state_r == ST_RUN);

  assign rd_addr_first  = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign rd_addr_second = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  always_comb begin
    step.valid     = (state_r == ST_RUN);
    step.row       = i_r;
    step.col       = j_r;
    step.first     = (k_r == '0);
    step.last_term = k_end;
    step.last_elem = k_end && j_end && i_end;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_nxt = k_r + IDX_W'(1);
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + IDX_W'(1);
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt = i_r + IDX_W'(1);
            end else begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        // Hold until the final element leaves the accumulator.
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sqmm_mac.sv
// ----------------------------------------------------------------------------
// sqmm_mac
// Multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqmm_mac
  import sqmm_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  sqmm_step_t               step,
  input  wire signed [ELEM_W-1:0]  rd_first,
  input  wire signed [ELEM_W-1:0]  rd_second,
  output logic                     done,
  output logic                     out_valid_r,
  output logic [IDX_W-1:0]         out_row_r,
  output logic [IDX_W-1:0]         out_column_r,
  output logic signed [ACC_W-1:0]  out_value_r,
  output logic                     out_last_r
);

  sqmm_step_t               step1_r, step2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // Restart the sum on the first term of each element.
  assign acc_nxt = step2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  assign done    = step2_r.valid && step2_r.last_term && step2_r.last_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step1_r.valid <= 1'b0;
      step2_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      step1_r.valid <= step.valid;
      step2_r.valid <= step1_r.valid;
      out_valid_r   <= step2_r.valid && step2_r.last_term;
    end
    step1_r.row       <= step.row;
    step1_r.col       <= step.col;
    step1_r.first     <= step.first;
    step1_r.last_term <= step.last_term;
    step1_r.last_elem <= step.last_elem;
    step2_r.row       <= step1_r.row;
    step2_r.col       <= step1_r.col;
    step2_r.first     <= step1_r.first;
    step2_r.last_term <= step1_r.last_term;
    step2_r.last_elem <= step1_r.last_elem;
    prod_r            <= rd_first * rd_second;
    if (step2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (step2_r.valid && step2_r.last_term) begin
      out_row_r    <= step2_r.row;
      out_column_r <= step2_r.col;
      out_value_r  <= acc_nxt;
      out_last_r   <= step2_r.last_elem;
    end
  end

endmodule

`default_nettype wire

### hdl/square_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply_top
// Loads two square Q8.8 matrices and streams their exact Q19.16 product.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. A load
// request (first or second matrix) writes one element in that cycle and
// leaves busy low, so loads go back to back at one per cycle; a load whose
// row or column lies outside MAX_DIM, and the unused command, do nothing.
// A compute request raises busy and runs n*n*n multiply-accumulate steps,
// n being the active size (cfg_data clamped to 1..MAX_DIM): one step per
// cycle, bounded by the single read port of each element memory, through
// registered read, multiply and accumulate stages. The product comes out
// row-major, one element per out_valid pulse, with out_last on the final
// one; busy falls in the cycle of that final pulse.
// out_valid is a one-cycle strobe: the receiver cannot stall it, so it must
// take every result as it appears. Write cfg_data only while busy is low.
// The element memories are not cleared: read only elements already loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module square_matrix_multiply_top
  import sqmm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // Request channel
  input  wire                      start,
  output logic                     busy,
  input  wire [CMD_W-1:0]          in_command,
  input  wire [IDX_W-1:0]          in_row,
  input  wire [IDX_W-1:0]          in_column,
  input  wire signed [ELEM_W-1:0]  in_element,
  // Size register
  input  wire                      cfg_we,
  input  wire [DIM_W-1:0]          cfg_data,
  // Result channel
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_column,
  output logic signed [ACC_W-1:0]  out_product_value,
  output logic                     out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     accept;
  logic                     in_range;
  logic                     we_first, we_second;
  logic [AW-1:0]            wr_addr;
  logic [DIM_W-1:0]         size_r;
  logic                     go;
  logic                     done;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr_first, rd_addr_second;
  logic signed [ELEM_W-1:0] rd_first, rd_second;
  sqmm_step_t               step;

  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_row} < DIM_W'(MAX_DIM)) &&
                    ({1'b0, in_column} < DIM_W'(MAX_DIM));
  assign wr_addr  = AW'(in_row) * AW'(MAX_DIM) + AW'(in_column);

  // Decode the request; drop loads outside the stores.
  always_comb begin
    we_first  = 1'b0;
    we_second = 1'b0;
    go        = 1'b0;
    unique case (sqmm_cmd_t'(in_command))
      CMD_LOAD_FIRST:  we_first  = accept && in_range;
      CMD_LOAD_SECOND: we_second = accept && in_range;
      CMD_COMPUTE:     go        = accept;
      default:         go        = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  sqmm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk            (clk),
    .we_first       (we_first),
    .we_second      (we_second),
    .wr_addr        (wr_addr),
    .wr_data        (in_element),
    .rd_en          (rd_en),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .rd_first_r     (rd_first),
    .rd_second_r    (rd_second)
  );

  // Busy covers the whole compute run, so no load can touch an element
  // while it is being read.
  sqmm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .size           (size_r),
    .done           (done),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .step           (step)
  );

  sqmm_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rd_first     (rd_first),
    .rd_second    (rd_second),
    .done         (done),
    .out_valid_r  (out_valid),
    .out_row_r    (out_row),
    .out_column_r (out_column),
    .out_value_r  (out_product_value),
    .out_last_r   (out_last)
  );

endmodule

`default_nettype wire
